// File: rtl/keyed_priority_task_queue_top_macros.svh
// Assertion macros shared by the task queue RTL.
`ifndef KEYED_PRIORITY_TASK_QUEUE_TOP_MACROS_SVH
`define KEYED_PRIORITY_TASK_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KPTQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KPTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/kptq_pkg.sv
// Types, codes and constants shared by the task queue modules.
package kptq_pkg;

  // Default sizing
  localparam int CAPACITY_DEF = 16;
  localparam int KEY_BITS_DEF = 32;

  // Field widths on the stream ports
  localparam int OP_W     = 3;
  localparam int KEY_IN_W = 32;
  localparam int PRIO_W   = 4;
  localparam int ST_W     = 3;
  localparam int AHEAD_W  = 4;
  localparam int S_DATA_W = ((KEY_IN_W + PRIO_W + 7) / 8) * 8;
  localparam int M_DATA_W = KEY_IN_W + PRIO_W + AHEAD_W;

  // Legal priority range
  localparam logic [PRIO_W-1:0] PRIO_MIN = 4'd1;
  localparam logic [PRIO_W-1:0] PRIO_MAX = 4'd10;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_FIND   = 3'd1,
    OP_EXEC   = 3'd2,
    OP_CANCEL = 3'd3,
    OP_LIST   = 3'd4,
    OP_CHANGE = 3'd5
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_MISSING = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4,
    ST_BADPRIO = 3'd5
  } status_e;

  // Read address relative to the entry index
  typedef enum logic [1:0] {
    RD_IDX  = 2'd0,
    RD_NEXT = 2'd1,
    RD_PREV = 2'd2
  } rd_sel_e;

  // Write source: the entry just read, or the new task
  typedef enum logic {
    WR_MOVE = 1'b0,
    WR_NEW  = 1'b1
  } wr_sel_e;

  typedef enum logic [2:0] {
    IDX_HOLD = 3'd0,
    IDX_ZERO = 3'd1,
    IDX_INC  = 3'd2,
    IDX_DEC  = 3'd3,
    IDX_OCC  = 3'd4
  } idx_op_e;

  // What goes into the output word
  typedef enum logic [1:0] {
    EM_PLAIN = 2'd0,
    EM_FIND  = 2'd1,
    EM_HEAD  = 2'd2,
    EM_PEND  = 2'd3
  } emit_kind_e;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       rd;
    rd_sel_e    rd_sel;
    logic       wr;
    wr_sel_e    wr_sel;
    idx_op_e    idx_op;
    logic       occ_inc;
    logic       occ_dec;
    logic       pend_set;
    logic       pend_clr;
    logic       emit;
    emit_kind_e emit_kind;
    status_e    emit_status;
    logic       emit_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_e  op;
    logic occ_zero;
    logic occ_full;
    logic idx_end;
    logic idx_zero;
    logic idx_last;
    logic key_eq;
    logic prio_eq;
    logic prio_lt;
    logic prio_ok;
    logic pend_v;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/kptq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kptq_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port, and read port that holds its data until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/kptq_datapath.sv
// Task store, index and occupancy counters, list buffer and output word register.
`include "keyed_priority_task_queue_top_macros.svh"

module kptq_datapath #(
  parameter int CAPACITY = kptq_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = kptq_pkg::KEY_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [kptq_pkg::OP_W-1:0]     in_op_i,
  input  logic [kptq_pkg::KEY_IN_W-1:0] in_key_i,
  input  logic [kptq_pkg::PRIO_W-1:0]   in_prio_i,
  input  kptq_pkg::cmd_t                cmd_i,
  output kptq_pkg::sts_t                sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [kptq_pkg::ST_W-1:0]     out_status_o,
  output logic [kptq_pkg::KEY_IN_W-1:0] out_key_o,
  output logic [kptq_pkg::PRIO_W-1:0]   out_prio_o,
  output logic [kptq_pkg::AHEAD_W-1:0]  out_ahead_o,
  output logic                          out_last_o
);

  localparam int IW  = $clog2(CAPACITY);
  localparam int OW  = $clog2(CAPACITY + 1);
  localparam int PW  = kptq_pkg::PRIO_W;
  localparam int EW  = KEY_BITS + PW;
  localparam int KOW = kptq_pkg::KEY_IN_W;
  localparam int AW  = kptq_pkg::AHEAD_W;

  // Latched operation
  kptq_pkg::op_e     op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [PW-1:0]       prio_q;

  // Counters
  logic [OW-1:0] idx_q, idx_d;
  logic [OW-1:0] occ_q, occ_d;

  // Pending list match
  logic                pend_v_q;
  logic [KEY_BITS-1:0] pend_key_q;

  // Store ports
  logic [OW-1:0]       rd_ptr;
  logic [EW-1:0]       wdata;
  logic [EW-1:0]       rdata;
  logic [KEY_BITS-1:0] rd_key;
  logic [PW-1:0]       rd_prio;
  logic [OW:0]         idx_plus1;

  // Output word
  logic                out_valid_q;
  logic [kptq_pkg::ST_W-1:0] out_status_q, em_status;
  logic [KOW-1:0]      out_key_q, em_key;
  logic [PW-1:0]       out_prio_q, em_prio;
  logic [AW-1:0]       out_ahead_q, em_ahead;
  logic                out_last_q;

  // Capture the operation
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= kptq_pkg::op_e'(in_op_i);
      key_q  <= KEY_BITS'(in_key_i);
      prio_q <= in_prio_i;
    end
  end

  // Select read address
  always_comb begin
    unique case (cmd_i.rd_sel)
      kptq_pkg::RD_NEXT: rd_ptr = idx_q + OW'(1);
      kptq_pkg::RD_PREV: rd_ptr = idx_q - OW'(1);
      default:           rd_ptr = idx_q;
    endcase
  end

  assign wdata   = (cmd_i.wr_sel == kptq_pkg::WR_NEW) ? {key_q, prio_q} : rdata;
  assign rd_key  = rdata[EW-1:PW];
  assign rd_prio = rdata[PW-1:0];

  kptq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .waddr_i (idx_q[IW-1:0]),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (rd_ptr[IW-1:0]),
    .rdata_o (rdata)
  );

  // Advance the entry index and occupancy
  always_comb begin
    unique case (cmd_i.idx_op)
      kptq_pkg::IDX_ZERO: idx_d = '0;
      kptq_pkg::IDX_INC:  idx_d = idx_q + OW'(1);
      kptq_pkg::IDX_DEC:  idx_d = idx_q - OW'(1);
      kptq_pkg::IDX_OCC:  idx_d = occ_q;
      default:            idx_d = idx_q;
    endcase
    occ_d = occ_q;
    if (cmd_i.occ_inc) begin
      occ_d = occ_q + OW'(1);
    end else if (cmd_i.occ_dec) begin
      occ_d = occ_q - OW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      occ_q    <= '0;
      pend_v_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      occ_q <= occ_d;
      if (cmd_i.pend_set) begin
        pend_v_q <= 1'b1;
      end else if (cmd_i.pend_clr) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_set) begin
      pend_key_q <= rd_key;
    end
  end

  // Status toward the controller
  assign idx_plus1 = {1'b0, idx_q} + (OW + 1)'(1);

  assign sts_o.op       = op_q;
  assign sts_o.occ_zero = (occ_q == '0);
  assign sts_o.occ_full = (occ_q == OW'(CAPACITY));
  assign sts_o.idx_end  = (idx_q == occ_q);
  assign sts_o.idx_zero = (idx_q == '0);
  assign sts_o.idx_last = (idx_plus1 >= {1'b0, occ_q});
  assign sts_o.key_eq   = (rd_key == key_q);
  assign sts_o.prio_eq  = (rd_prio == prio_q);
  assign sts_o.prio_lt  = (rd_prio < prio_q);
  assign sts_o.prio_ok  = (prio_q >= kptq_pkg::PRIO_MIN) && (prio_q <= kptq_pkg::PRIO_MAX);
  assign sts_o.pend_v   = pend_v_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Build the output word
  always_comb begin
    em_status = cmd_i.emit_status;
    em_key    = '0;
    em_prio   = '0;
    em_ahead  = '0;
    unique case (cmd_i.emit_kind)
      kptq_pkg::EM_FIND: begin
        em_status = kptq_pkg::ST_OK;
        em_ahead  = AW'(idx_q);
      end
      kptq_pkg::EM_HEAD: begin
        em_status = kptq_pkg::ST_OK;
        em_key    = KOW'(rd_key);
        em_prio   = rd_prio;
      end
      kptq_pkg::EM_PEND: begin
        em_status = kptq_pkg::ST_OK;
        em_key    = KOW'(pend_key_q);
        em_prio   = prio_q;
      end
      default: begin
      end
    endcase
  end

  // Hold the word until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= em_status;
      out_key_q    <= em_key;
      out_prio_q   <= em_prio;
      out_ahead_q  <= em_ahead;
      out_last_q   <= cmd_i.emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_key_o    = out_key_q;
  assign out_prio_o   = out_prio_q;
  assign out_ahead_o  = out_ahead_q;
  assign out_last_o   = out_last_q;

  `KPTQ_ASSERT_IMPL(a_occ_bound, clk_i, rst_ni, 1'b1, occ_q <= OW'(CAPACITY), "occupancy above capacity")
  `KPTQ_ASSERT_IMPL(a_wr_in_range, clk_i, rst_ni, cmd_i.wr, idx_q < OW'(CAPACITY), "store write out of range")
  `KPTQ_ASSERT_NEXT(a_occ_inc, clk_i, rst_ni, cmd_i.occ_inc, occ_q == $past(occ_q) + OW'(1), "occupancy step lost")

endmodule

// File: rtl/kptq_ctrl.sv
// Operation sequencer: scans, shifts and result ordering for the task queue.
`include "keyed_priority_task_queue_top_macros.svh"

module kptq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  kptq_pkg::sts_t sts_i,
  output kptq_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_LOC_RD   = 4'd2;
  localparam logic [3:0] S_LOC_EV   = 4'd3;
  localparam logic [3:0] S_REM_RD   = 4'd4;
  localparam logic [3:0] S_REM_WR   = 4'd5;
  localparam logic [3:0] S_INS_CHK  = 4'd6;
  localparam logic [3:0] S_INS_RD   = 4'd7;
  localparam logic [3:0] S_INS_EV   = 4'd8;
  localparam logic [3:0] S_EXE_EV   = 4'd9;
  localparam logic [3:0] S_LST_RD   = 4'd10;
  localparam logic [3:0] S_LST_EV   = 4'd11;
  localparam logic [3:0] S_LST_FIN  = 4'd12;
  localparam logic [3:0] S_EMIT     = 4'd13;

  logic [3:0] state_q, state_d;
  kptq_pkg::emit_kind_e kind_q, kind_d;
  kptq_pkg::status_e    code_q, code_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    kind_d  = kind_q;
    code_d  = code_q;
    unique case (state_q)
      // Latch the word and reset the scan
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load     = 1'b1;
          cmd_o.idx_op   = kptq_pkg::IDX_ZERO;
          cmd_o.pend_clr = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      // Early rejects, then pick the first pass
      S_DISPATCH: begin
        kind_d = kptq_pkg::EM_PLAIN;
        unique case (sts_i.op)
          kptq_pkg::OP_INSERT, kptq_pkg::OP_CHANGE: begin
            if (!sts_i.prio_ok) begin
              code_d  = kptq_pkg::ST_BADPRIO;
              state_d = S_EMIT;
            end else begin
              state_d = S_LOC_RD;
            end
          end
          kptq_pkg::OP_FIND, kptq_pkg::OP_CANCEL: begin
            if (sts_i.occ_zero) begin
              code_d  = kptq_pkg::ST_EMPTY;
              state_d = S_EMIT;
            end else begin
              state_d = S_LOC_RD;
            end
          end
          kptq_pkg::OP_EXEC: begin
            if (sts_i.occ_zero) begin
              code_d  = kptq_pkg::ST_EMPTY;
              state_d = S_EMIT;
            end else begin
              cmd_o.rd     = 1'b1;
              cmd_o.rd_sel = kptq_pkg::RD_IDX;
              state_d      = S_EXE_EV;
            end
          end
          kptq_pkg::OP_LIST: begin
            if (sts_i.occ_zero) begin
              code_d  = kptq_pkg::ST_EMPTY;
              state_d = S_EMIT;
            end else begin
              state_d = S_LST_RD;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      // Search the key from the head: read an entry, then check it
      S_LOC_RD: begin
        if (sts_i.idx_end) begin
          if (sts_i.op == kptq_pkg::OP_INSERT || sts_i.op == kptq_pkg::OP_CHANGE) begin
            state_d = S_INS_CHK;
          end else begin
            kind_d  = kptq_pkg::EM_PLAIN;
            code_d  = kptq_pkg::ST_MISSING;
            state_d = S_EMIT;
          end
        end else begin
          cmd_o.rd     = 1'b1;
          cmd_o.rd_sel = kptq_pkg::RD_IDX;
          state_d      = S_LOC_EV;
        end
      end
      S_LOC_EV: begin
        if (sts_i.key_eq) begin
          if (sts_i.op == kptq_pkg::OP_FIND) begin
            kind_d  = kptq_pkg::EM_FIND;
            code_d  = kptq_pkg::ST_OK;
            state_d = S_EMIT;
          end else if (sts_i.op == kptq_pkg::OP_INSERT) begin
            kind_d  = kptq_pkg::EM_PLAIN;
            code_d  = kptq_pkg::ST_DUP;
            state_d = S_EMIT;
          end else begin
            state_d = S_REM_RD;
          end
        end else begin
          cmd_o.idx_op = kptq_pkg::IDX_INC;
          state_d      = S_LOC_RD;
        end
      end
      // Close the gap: move each later entry down by one
      S_REM_RD: begin
        if (sts_i.idx_last) begin
          cmd_o.occ_dec = 1'b1;
          if (sts_i.op == kptq_pkg::OP_CANCEL) begin
            kind_d  = kptq_pkg::EM_PLAIN;
            code_d  = kptq_pkg::ST_OK;
            state_d = S_EMIT;
          end else if (sts_i.op == kptq_pkg::OP_CHANGE) begin
            state_d = S_INS_CHK;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.rd     = 1'b1;
          cmd_o.rd_sel = kptq_pkg::RD_NEXT;
          state_d      = S_REM_WR;
        end
      end
      S_REM_WR: begin
        cmd_o.wr     = 1'b1;
        cmd_o.wr_sel = kptq_pkg::WR_MOVE;
        cmd_o.idx_op = kptq_pkg::IDX_INC;
        state_d      = S_REM_RD;
      end
      // Full check, then walk up from the tail
      S_INS_CHK: begin
        if (sts_i.occ_full) begin
          kind_d  = kptq_pkg::EM_PLAIN;
          code_d  = kptq_pkg::ST_FULL;
          state_d = S_EMIT;
        end else begin
          cmd_o.idx_op = kptq_pkg::IDX_OCC;
          state_d      = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (sts_i.idx_zero) begin
          cmd_o.wr      = 1'b1;
          cmd_o.wr_sel  = kptq_pkg::WR_NEW;
          cmd_o.occ_inc = 1'b1;
          kind_d        = kptq_pkg::EM_PLAIN;
          code_d        = kptq_pkg::ST_OK;
          state_d       = S_EMIT;
        end else begin
          cmd_o.rd     = 1'b1;
          cmd_o.rd_sel = kptq_pkg::RD_PREV;
          state_d      = S_INS_EV;
        end
      end
      // Stop behind an entry of equal or higher priority
      S_INS_EV: begin
        cmd_o.wr = 1'b1;
        if (!sts_i.prio_lt) begin
          cmd_o.wr_sel  = kptq_pkg::WR_NEW;
          cmd_o.occ_inc = 1'b1;
          kind_d        = kptq_pkg::EM_PLAIN;
          code_d        = kptq_pkg::ST_OK;
          state_d       = S_EMIT;
        end else begin
          cmd_o.wr_sel = kptq_pkg::WR_MOVE;
          cmd_o.idx_op = kptq_pkg::IDX_DEC;
          state_d      = S_INS_RD;
        end
      end
      // Send the head, then remove it
      S_EXE_EV: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = kptq_pkg::EM_HEAD;
          cmd_o.emit_last = 1'b1;
          state_d         = S_REM_RD;
        end
      end
      // List: one match is held back so the final word can carry last
      S_LST_RD: begin
        if (sts_i.idx_end) begin
          state_d = S_LST_FIN;
        end else begin
          cmd_o.rd     = 1'b1;
          cmd_o.rd_sel = kptq_pkg::RD_IDX;
          state_d      = S_LST_EV;
        end
      end
      S_LST_EV: begin
        if (sts_i.prio_eq) begin
          if (!sts_i.pend_v || sts_i.out_free) begin
            cmd_o.emit      = sts_i.pend_v;
            cmd_o.emit_kind = kptq_pkg::EM_PEND;
            cmd_o.pend_set  = 1'b1;
            cmd_o.idx_op    = kptq_pkg::IDX_INC;
            state_d         = S_LST_RD;
          end
        end else if (sts_i.prio_lt) begin
          state_d = S_LST_FIN;
        end else begin
          cmd_o.idx_op = kptq_pkg::IDX_INC;
          state_d      = S_LST_RD;
        end
      end
      S_LST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_kind   = sts_i.pend_v ? kptq_pkg::EM_PEND : kptq_pkg::EM_PLAIN;
          cmd_o.emit_status = kptq_pkg::ST_MISSING;
          state_d           = S_IDLE;
        end
      end
      // Single closing word
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_kind   = kind_q;
          cmd_o.emit_status = code_q;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= kptq_pkg::EM_PLAIN;
      code_q  <= kptq_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      code_q  <= code_d;
    end
  end

  `KPTQ_ASSERT_NEXT(a_load_dispatch, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == S_DISPATCH, "accepted word not dispatched")
  `KPTQ_ASSERT_IMPL(a_emit_free, clk_i, rst_ni, cmd_o.emit, sts_i.out_free, "output word overwritten")
  `KPTQ_ASSERT_IMPL(a_one_occ_step, clk_i, rst_ni, cmd_o.occ_inc, !cmd_o.occ_dec && cmd_o.wr, "insert without store write")

endmodule

// File: rtl/keyed_priority_task_queue_top.sv
// Top level of the keyed priority task queue: stream ports, sequencer and datapath.
// A search or a list walks the entries from the head; a removal or an insert moves the
// entries behind the slot one at a time. One request word is handled at a time: the next
// is taken only once the last one is done, output stalls included. Each entry step is a read
// state and a check or write state; the store's one read port has registered read data.
// Reset: occupancy clears at once and no clearing pass runs; the store starts unwritten.
module keyed_priority_task_queue_top #(
  parameter int CAPACITY = kptq_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = kptq_pkg::KEY_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // task_key [31:0], priority_req [35:32], zero pad [39:36]
  input  logic [kptq_pkg::S_DATA_W-1:0] s_axis_tdata,
  // operation [2:0]
  input  logic [kptq_pkg::OP_W-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_key [31:0], out_priority [35:32], ahead_count [39:36]
  output logic [kptq_pkg::M_DATA_W-1:0] m_axis_tdata,
  // status [2:0]
  output logic [kptq_pkg::ST_W-1:0]     m_axis_tuser,
  output logic                          m_axis_tlast
);

  localparam int KW = kptq_pkg::KEY_IN_W;
  localparam int PW = kptq_pkg::PRIO_W;

  kptq_pkg::cmd_t cmd;
  kptq_pkg::sts_t sts;

  logic [KW-1:0]                  out_key;
  logic [PW-1:0]                  out_prio;
  logic [kptq_pkg::AHEAD_W-1:0]   out_ahead;

  kptq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kptq_datapath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_op_i      (s_axis_tuser),
    .in_key_i     (s_axis_tdata[KW-1:0]),
    .in_prio_i    (s_axis_tdata[KW +: PW]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_key_o    (out_key),
    .out_prio_o   (out_prio),
    .out_ahead_o  (out_ahead),
    .out_last_o   (m_axis_tlast)
  );

  // Pack the result word
  assign m_axis_tdata = {out_ahead, out_prio, out_key};

endmodule

// File: tb/tb_keyed_priority_task_queue_top.sv
// Self-checking testbench for the keyed priority task queue: random and directed stream traffic.
`timescale 1ns / 1ps

module tb_keyed_priority_task_queue_top;
  import kptq_pkg::*;

  localparam int SLOTS       = CAPACITY_DEF;
  localparam int POOL_SIZE   = 24;
  localparam int SETTLE_CYC  = 6 * SLOTS + 24;
  localparam int MAX_REPORTS = 10;

  // One result word as the block presents it
  typedef struct packed {
    status_e           status;
    logic [KEY_IN_W-1:0] key;
    logic [PRIO_W-1:0] prio;
    logic [AHEAD_W-1:0] ahead;
    logic              last;
  } task_result_t;

  // Mirror of the task store: predicts result words and checks them in order
  class task_queue_mirror;
    logic [KEY_IN_W-1:0] keys [SLOTS];
    logic [PRIO_W-1:0]   prios[SLOTS];
    int                  occ;
    task_result_t        due_results[$];
    int                  fail_count;

    function new();
      occ        = 0;
      fail_count = 0;
    endfunction

    function void flag_failure(string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
    endfunction

    // Index of key, or occ when absent
    function int slot_of(logic [KEY_IN_W-1:0] key);
      for (int i = 0; i < occ; i++) begin
        if (keys[i] == key) return i;
      end
      return occ;
    endfunction

    // Close the gap left by slot pos
    function void drop_slot(int pos);
      for (int i = pos; i + 1 < occ; i++) begin
        keys[i]  = keys[i+1];
        prios[i] = prios[i+1];
      end
      occ--;
    endfunction

    // Insert behind every task of equal or higher rank
    function status_e place_task(logic [KEY_IN_W-1:0] key, logic [PRIO_W-1:0] prio);
      int pos;
      if (prio < PRIO_MIN || prio > PRIO_MAX) return ST_BADPRIO;
      if (slot_of(key) < occ) return ST_DUP;
      if (occ >= SLOTS) return ST_FULL;
      pos = 0;
      while (pos < occ && prios[pos] >= prio) pos++;
      for (int i = occ; i > pos; i--) begin
        keys[i]  = keys[i-1];
        prios[i] = prios[i-1];
      end
      keys[pos]  = key;
      prios[pos] = prio;
      occ++;
      return ST_OK;
    endfunction

    function void push_result(status_e st, logic [KEY_IN_W-1:0] key,
                              logic [PRIO_W-1:0] prio, logic [AHEAD_W-1:0] ahead,
                              logic last);
      task_result_t r;
      r.status = st;
      r.key    = key;
      r.prio   = prio;
      r.ahead  = ahead;
      r.last   = last;
      due_results.push_back(r);
    endfunction

    // Update the store for one accepted word and queue the words it produces
    function void apply_request(logic [OP_W-1:0] op, logic [KEY_IN_W-1:0] key,
                                logic [PRIO_W-1:0] prio);
      int pos;
      int hits;
      task_result_t tail;
      case (op)
        OP_INSERT: begin
          push_result(place_task(key, prio), '0, '0, '0, 1'b1);
        end
        OP_FIND: begin
          pos = slot_of(key);
          if (occ == 0) push_result(ST_EMPTY, '0, '0, '0, 1'b1);
          else if (pos < occ) push_result(ST_OK, '0, '0, AHEAD_W'(pos), 1'b1);
          else push_result(ST_MISSING, '0, '0, '0, 1'b1);
        end
        OP_EXEC: begin
          if (occ == 0) begin
            push_result(ST_EMPTY, '0, '0, '0, 1'b1);
          end else begin
            push_result(ST_OK, keys[0], prios[0], '0, 1'b1);
            drop_slot(0);
          end
        end
        OP_CANCEL: begin
          pos = slot_of(key);
          if (occ == 0) begin
            push_result(ST_EMPTY, '0, '0, '0, 1'b1);
          end else if (pos < occ) begin
            drop_slot(pos);
            push_result(ST_OK, '0, '0, '0, 1'b1);
          end else begin
            push_result(ST_MISSING, '0, '0, '0, 1'b1);
          end
        end
        OP_LIST: begin
          hits = 0;
          if (occ == 0) begin
            push_result(ST_EMPTY, '0, '0, '0, 1'b1);
          end else begin
            // walk in service order, stop at the first lower rank
            for (int i = 0; i < occ; i++) begin
              if (prios[i] == prio) begin
                push_result(ST_OK, keys[i], prios[i], '0, 1'b0);
                hits++;
              end else if (prios[i] < prio) begin
                break;
              end
            end
            if (hits == 0) begin
              push_result(ST_MISSING, '0, '0, '0, 1'b1);
            end else begin
              // mark the final match
              tail      = due_results.pop_back();
              tail.last = 1'b1;
              due_results.push_back(tail);
            end
          end
        end
        OP_CHANGE: begin
          if (prio < PRIO_MIN || prio > PRIO_MAX) begin
            push_result(ST_BADPRIO, '0, '0, '0, 1'b1);
          end else begin
            pos = slot_of(key);
            if (pos < occ) drop_slot(pos);
            push_result(place_task(key, prio), '0, '0, '0, 1'b1);
          end
        end
        default: begin
          // unused codes: no word out, store untouched
        end
      endcase
    endfunction

    // Compare one accepted output word with the oldest prediction
    function void check_result(task_result_t got);
      task_result_t exp;
      if (due_results.size() == 0) begin
        flag_failure($sformatf("unexpected word: st=%0d key=%h prio=%0d ahead=%0d last=%b",
                               got.status, got.key, got.prio, got.ahead, got.last));
        return;
      end
      exp = due_results.pop_front();
      if (got !== exp) begin
        flag_failure({
          $sformatf("mismatch: exp st=%0d key=%h prio=%0d ahead=%0d last=%b",
                    exp.status, exp.key, exp.prio, exp.ahead, exp.last),
          $sformatf(", got st=%0d key=%h prio=%0d ahead=%0d last=%b",
                    got.status, got.key, got.prio, got.ahead, got.last)});
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic [OP_W-1:0]     s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [ST_W-1:0]     m_axis_tuser;
  logic                m_axis_tlast;

  task_queue_mirror    mirror;
  logic                no_idle = 1'b0;
  logic [KEY_IN_W-1:0] key_pool[POOL_SIZE];

  keyed_priority_task_queue_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 250 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  // Present one request word and hold it until accepted
  task automatic send_request(logic [OP_W-1:0] op, logic [KEY_IN_W-1:0] key,
                              logic [PRIO_W-1:0] prio);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(S_DATA_W - KEY_IN_W - PRIO_W){1'b0}}, prio, key};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    mirror.apply_request(op, key, prio);
  endtask

  // Hold off until every predicted word has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (mirror.due_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [PRIO_W-1:0] pick_prio();
    return ($urandom_range(0, 99) < 85) ? PRIO_W'($urandom_range(1, 10))
                                         : PRIO_W'($urandom_range(0, 15));
  endfunction

  function automatic logic [KEY_IN_W-1:0] pick_key();
    return ($urandom_range(0, 9) == 0) ? KEY_IN_W'($urandom)
                                        : key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Operation mix per phase: 0 fill, 1 mixed, 2 drain
  function automatic logic [OP_W-1:0] pick_op(int phase);
    int r;
    r = $urandom_range(0, 99);
    case (phase)
      0: begin
        if (r < 65) return OP_INSERT;
        if (r < 75) return OP_CHANGE;
        if (r < 85) return OP_FIND;
        if (r < 93) return OP_LIST;
        return OP_CANCEL;
      end
      1: begin
        if (r < 6) return OP_W'($urandom_range(6, 7));
        return OP_W'($urandom_range(0, 5));
      end
      default: begin
        if (r < 40) return OP_EXEC;
        if (r < 60) return OP_CANCEL;
        if (r < 70) return OP_INSERT;
        if (r < 80) return OP_FIND;
        if (r < 90) return OP_LIST;
        return OP_CHANGE;
      end
    endcase
  endfunction

  // Accept output words with random stalls and check each one
  initial begin
    task_result_t got;
    int stall;
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      got.status = status_e'(m_axis_tuser);
      got.key    = m_axis_tdata[KEY_IN_W-1:0];
      got.prio   = m_axis_tdata[KEY_IN_W +: PRIO_W];
      got.ahead  = m_axis_tdata[KEY_IN_W + PRIO_W +: AHEAD_W];
      got.last   = m_axis_tlast;
      mirror.check_result(got);
    end
  end

  // Stimulus
  initial begin
    logic [KEY_IN_W-1:0] ka, kb, kc;
    mirror = new();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_IN_W'($urandom);
    ka = key_pool[2];
    kb = key_pool[3];
    kc = key_pool[4];

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty store, bad ranks, duplicates, lists, changes, unused codes
    send_request(OP_FIND,   key_pool[0], 4'd1);
    send_request(OP_EXEC,   key_pool[0], 4'd0);
    send_request(OP_CANCEL, key_pool[1], 4'd0);
    send_request(OP_LIST,   key_pool[0], 4'd5);
    send_request(OP_CHANGE, key_pool[0], 4'd10);
    send_request(OP_INSERT, ka, 4'd0);
    send_request(OP_INSERT, ka, 4'd11);
    send_request(OP_INSERT, ka, 4'd15);
    send_request(OP_INSERT, key_pool[1], 4'd1);
    send_request(OP_INSERT, key_pool[0], 4'd5);
    send_request(OP_INSERT, ka, 4'd10);
    send_request(OP_INSERT, kb, 4'd1);
    send_request(OP_FIND,   kb, 4'd0);
    send_request(OP_FIND,   kc, 4'd0);
    send_request(OP_LIST,   kc, 4'd10);
    send_request(OP_LIST,   kc, 4'd1);
    send_request(OP_LIST,   kc, 4'd7);
    send_request(OP_LIST,   kc, 4'd0);
    send_request(OP_LIST,   kc, 4'd15);
    send_request(OP_CHANGE, ka, 4'd15);
    send_request(OP_CHANGE, kb, 4'd10);
    send_request(OP_CHANGE, kc, 4'd3);
    send_request(OP_CANCEL, key_pool[5], 4'd2);
    send_request(OP_CANCEL, ka, 4'd2);
    send_request(3'd6, kc, 4'd4);
    send_request(3'd7, kb, 4'd9);
    send_request(OP_EXEC, key_pool[0], 4'd0);
    wait_drained();

    // Fill toward a full store, then mixed traffic, then drain
    for (int i = 0; i < 40; i++) send_request(pick_op(0), pick_key(), pick_prio());
    wait_drained();
    for (int i = 0; i < 60; i++) begin
      no_idle = (i >= 20 && i < 40);
      send_request(pick_op(1), pick_key(), pick_prio());
    end
    no_idle = 1'b0;
    wait_drained();
    for (int i = 0; i < 43; i++) send_request(pick_op(2), pick_key(), pick_prio());

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mirror.fail_count == 0 && mirror.due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
